/* hw/rtl/encvel_pkg.sv */
`default_nettype none

package encvel_pkg;

  typedef enum logic [2:0] {
    OP_PROCESS = 3'd0,
    OP_SYNC    = 3'd1,
    OP_RESET   = 3'd2,
    OP_DISABLE = 3'd3,
    OP_ENABLE  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SAMPLE,
    ST_ADD,
    ST_MUL1,
    ST_MUL2,
    ST_ABS,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic CFG_COUNT_SIGN    = 1'b0;
  localparam logic CFG_SAMPLE_PERIOD = 1'b1;

  localparam logic [1:0] COUNT_SIGN_RST    = 2'b01;
  localparam logic [7:0] SAMPLE_PERIOD_RST = 8'd5;

  localparam int DSUM_W = 40;
  localparam int ACC_W  = 51;
  localparam int DIV_W  = 50;
  localparam int QUOT_W = 31;
  localparam int CNT_W  = 6;

  localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VEL_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

/* hw/rtl/encoder_count_and_window_velocity_core.sv */
// A velocity sample item passes the window update and multiply states and, unless the time
// sum is zero, the bit-serial divider (one quotient bit per cycle) before its result is
// loaded. One item is worked on at a time; the next word is accepted the cycle after the
// result is loaded, even while that result still waits to be taken.
// Reset clears position, window and velocity, sets the sign to plus one, the sample
// period to 5 ms and leaves the block active and unprimed.
`default_nettype none

module encoder_count_and_window_velocity_core #(
  parameter int WINDOW_SAMPLES = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [15:0]        hw_counter_i,
  input  wire logic [31:0]        now_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      position_o,
  output logic signed [31:0]      speed_o
);

  localparam int SLOT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int FILL_W = $clog2(WINDOW_SAMPLES + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SAMPLES - 1);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW_SAMPLES);
  localparam int DW = encvel_pkg::DSUM_W;
  localparam int AW = encvel_pkg::ACC_W;
  localparam int VW = encvel_pkg::DIV_W;
  localparam int QW = encvel_pkg::QUOT_W;
  localparam int CW = encvel_pkg::CNT_W;

  encvel_pkg::state_e state_q, state_d;

  logic [1:0]        sign_q;
  logic [7:0]        period_q;
  logic [31:0]       pos_q;
  logic [15:0]       last_q;
  logic [31:0]       vel_q;
  logic [31:0]       prev_count_q;
  logic [31:0]       prev_time_q;
  logic [DW-1:0]     dsum_q;
  logic [31:0]       esum_q;
  logic [SLOT_W-1:0] slot_q;
  logic [FILL_W-1:0] fill_q;
  logic              primed_q;
  logic              active_q;
  logic              out_valid_q;

  logic [2:0]        op_q;
  logic [15:0]       hw_q;
  logic [31:0]       now_q;
  logic [31:0]       delta_ring_q [WINDOW_SAMPLES];
  logic [31:0]       elapsed_ring_q [WINDOW_SAMPLES];
  logic [31:0]       dnew_q;
  logic [31:0]       enew_q;
  logic              neg_q;
  logic [AW-1:0]     acc_q;
  logic [VW-1:0]     dvd_q;
  logic [31:0]       rem_q;
  logic [QW-1:0]     quot_q;
  logic              ovf_q;
  logic [CW-1:0]     cnt_q;
  logic [31:0]       pos_out_q;
  logic [31:0]       vel_out_q;

  logic              accept;
  logic              load;
  logic [15:0]       diff16;
  logic [31:0]       ext32;
  logic [31:0]       pos_sync;
  logic [31:0]       elapsed;
  logic              early;
  logic              full;
  logic [31:0]       delta;
  logic [31:0]       old_d;
  logic [31:0]       old_e;
  logic [AW-1:0]     ds_ext;
  logic [AW-1:0]     half;
  logic [AW-1:0]     mag;
  logic [32:0]       shifted;
  logic [32:0]       trial;
  logic              ge;
  logic [31:0]       qmag;
  logic [31:0]       vel_res;

  assign in_ready_o          = (state_q == encvel_pkg::ST_IDLE);
  assign accept              = in_valid_i && in_ready_o;
  assign load                = (state_q == encvel_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o         = out_valid_q;
  assign position_o          = pos_out_q;
  assign speed_o             = vel_out_q;

  assign diff16   = hw_q - last_q;
  assign ext32    = {{16{diff16[15]}}, diff16};
  assign pos_sync = sign_q[1] ? (pos_q - ext32) : (pos_q + ext32);
  assign elapsed  = now_q - prev_time_q;
  assign early    = elapsed < {24'd0, period_q};
  assign full     = (fill_q == FILL_MAX);
  assign delta    = pos_q - prev_count_q;
  assign old_d    = delta_ring_q[slot_q];
  assign old_e    = elapsed_ring_q[slot_q];
  assign ds_ext   = {{(AW-DW){dsum_q[DW-1]}}, dsum_q};
  assign half     = {{(AW-31){1'b0}}, esum_q[31:1]};
  assign mag      = neg_q ? (half - acc_q) : (acc_q + half);
  assign shifted  = {rem_q, dvd_q[VW-1]};
  assign trial    = shifted - {1'b0, esum_q};
  assign ge       = !trial[32];
  assign qmag     = {1'b0, quot_q};
  assign vel_res  = ovf_q ? (neg_q ? encvel_pkg::VEL_MIN : encvel_pkg::VEL_MAX)
                          : (neg_q ? (32'd0 - qmag) : qmag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= encvel_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      encvel_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = encvel_pkg::ST_EXEC;
        end
      end
      encvel_pkg::ST_EXEC: begin
        if ((op_q == encvel_pkg::OP_PROCESS) && active_q) begin
          state_d = encvel_pkg::ST_SAMPLE;
        end else begin
          state_d = encvel_pkg::ST_OUT;
        end
      end
      encvel_pkg::ST_SAMPLE: begin
        if (!primed_q || early) begin
          state_d = encvel_pkg::ST_OUT;
        end else begin
          state_d = encvel_pkg::ST_ADD;
        end
      end
      encvel_pkg::ST_ADD: state_d = encvel_pkg::ST_MUL1;
      encvel_pkg::ST_MUL1: begin
        if (esum_q == 32'd0) begin
          state_d = encvel_pkg::ST_OUT;
        end else begin
          state_d = encvel_pkg::ST_MUL2;
        end
      end
      encvel_pkg::ST_MUL2: state_d = encvel_pkg::ST_ABS;
      encvel_pkg::ST_ABS: state_d = encvel_pkg::ST_DIV;
      encvel_pkg::ST_DIV: begin
        if (cnt_q == CW'(VW - 1)) begin
          state_d = encvel_pkg::ST_FIN;
        end
      end
      encvel_pkg::ST_FIN: state_d = encvel_pkg::ST_OUT;
      encvel_pkg::ST_OUT: begin
        if (load) begin
          state_d = encvel_pkg::ST_IDLE;
        end
      end
      default: state_d = encvel_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q       <= encvel_pkg::COUNT_SIGN_RST;
      period_q     <= encvel_pkg::SAMPLE_PERIOD_RST;
      pos_q        <= '0;
      last_q       <= '0;
      vel_q        <= '0;
      prev_count_q <= '0;
      prev_time_q  <= '0;
      dsum_q       <= '0;
      esum_q       <= '0;
      slot_q       <= '0;
      fill_q       <= '0;
      primed_q     <= 1'b0;
      active_q     <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          encvel_pkg::CFG_COUNT_SIGN:    sign_q   <= cfg_wdata_i[1:0];
          encvel_pkg::CFG_SAMPLE_PERIOD: period_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        encvel_pkg::ST_EXEC: begin
          unique case (op_q)
            encvel_pkg::OP_PROCESS, encvel_pkg::OP_SYNC: begin
              if (active_q) begin
                pos_q  <= pos_sync;
                last_q <= hw_q;
              end
            end
            encvel_pkg::OP_RESET: begin
              pos_q        <= '0;
              last_q       <= hw_q;
              vel_q        <= '0;
              dsum_q       <= '0;
              esum_q       <= '0;
              slot_q       <= '0;
              fill_q       <= '0;
              prev_count_q <= '0;
              primed_q     <= 1'b0;
            end
            encvel_pkg::OP_DISABLE: begin
              if (active_q) begin
                pos_q        <= pos_sync;
                last_q       <= hw_q;
                active_q     <= 1'b0;
                vel_q        <= '0;
                dsum_q       <= '0;
                esum_q       <= '0;
                slot_q       <= '0;
                fill_q       <= '0;
                prev_count_q <= pos_sync;
                primed_q     <= 1'b0;
              end
            end
            encvel_pkg::OP_ENABLE: begin
              if (!active_q) begin
                last_q       <= hw_q;
                active_q     <= 1'b1;
                vel_q        <= '0;
                dsum_q       <= '0;
                esum_q       <= '0;
                slot_q       <= '0;
                fill_q       <= '0;
                prev_count_q <= pos_q;
                primed_q     <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        encvel_pkg::ST_SAMPLE: begin
          if (!primed_q) begin
            prev_count_q <= pos_q;
            prev_time_q  <= now_q;
            vel_q        <= '0;
            primed_q     <= 1'b1;
          end else if (!early) begin
            if (full) begin
              dsum_q <= dsum_q - {{(DW-32){old_d[31]}}, old_d};
              esum_q <= esum_q - old_e;
            end else begin
              fill_q <= fill_q + FILL_W'(1);
            end
            prev_count_q <= pos_q;
            prev_time_q  <= now_q;
          end
        end
        encvel_pkg::ST_ADD: begin
          dsum_q <= dsum_q + {{(DW-32){dnew_q[31]}}, dnew_q};
          esum_q <= esum_q + enew_q;
          slot_q <= (slot_q == SLOT_LAST) ? '0 : (slot_q + SLOT_W'(1));
        end
        encvel_pkg::ST_MUL1: begin
          if (esum_q == 32'd0) begin
            vel_q <= '0;
          end
        end
        encvel_pkg::ST_FIN: vel_q <= vel_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      hw_q  <= hw_counter_i;
      now_q <= now_ms_i;
    end
    if ((state_q == encvel_pkg::ST_SAMPLE) && primed_q && !early) begin
      delta_ring_q[slot_q]   <= delta;
      elapsed_ring_q[slot_q] <= elapsed;
      dnew_q                 <= delta;
      enew_q                 <= elapsed;
    end
    if (state_q == encvel_pkg::ST_MUL1) begin
      acc_q <= (ds_ext << 10) - (ds_ext << 4);
      neg_q <= dsum_q[DW-1];
    end
    if (state_q == encvel_pkg::ST_MUL2) begin
      acc_q <= acc_q - (ds_ext << 3);
    end
    if (state_q == encvel_pkg::ST_ABS) begin
      dvd_q  <= mag[VW-1:0];
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end
    if (state_q == encvel_pkg::ST_DIV) begin
      rem_q  <= ge ? trial[31:0] : shifted[31:0];
      dvd_q  <= {dvd_q[VW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
      ovf_q  <= ovf_q | quot_q[QW-1];
      cnt_q  <= cnt_q + CW'(1);
    end
    if (load) begin
      pos_out_q <= pos_q;
      vel_out_q <= vel_q;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX) else $error("Window fill count exceeds the window size.");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST) else $error("Window slot index out of range.");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == encvel_pkg::ST_DIV) |-> (esum_q != 32'd0))
    else $error("Division started with a zero time sum.");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == encvel_pkg::ST_DIV) |-> (rem_q < esum_q))
    else $error("Divider remainder not below the divisor.");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (state_q == encvel_pkg::ST_IDLE)))
    else $error("Result load did not present a word and return to idle.");
`endif

endmodule

`default_nettype wire
